FILE: rtl/core/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Opcodes, sequencer states and word types shared by the unit.
// ----------------------------------------------------------------------------
package mau_pkg;

   localparam int unsigned FIELD_BITS = 32;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_POW = 3'd4
   } opcode_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [FIELD_BITS-1:0] operand_a;
      logic [FIELD_BITS-1:0] operand_b;
      logic [FIELD_BITS-1:0] modulus;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] result_value;
      logic                  a_less_than_b;
      logic                  a_equals_b;
      logic                  bad_modulus;
   } rsp_word_type;

   // one-hot sequencer states
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RED   = 8'b0000_0010,
      ST_DISP  = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_POWSQ = 8'b0001_0000,
      ST_POWML = 8'b0010_0000,
      ST_DONE  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

endpackage

FILE: rtl/core/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply, Fermat divide and power modulo N, with compare flags.
// ----------------------------------------------------------------------------
// Add/subtract time is spent mostly on the restoring reduction of both operands;
// multiply adds one modular multiply; power adds one or two modular multiplies
// per exponent bit; divide runs a power with exponent N-2, then one more
// multiply. One word at a time.
// Reset (synchronous, active high) returns the sequencer to idle.
module modular_arithmetic_unit import mau_pkg::*; #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int unsigned CW = $clog2(WORD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   state_type   state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   word_type    n_ff, n_in, b_ff, b_in, e_ff, e_in;
   word_type    ra_ff, ra_in;
   word_type    acc_ff, acc_in;     // multiply / reduce accumulator
   word_type    mx_ff, mx_in, my_ff, my_in;
   word_type    pacc_ff, pacc_in;   // power accumulator
   word_type    pbase_ff, pbase_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] ebit_ff, ebit_in; // exponent bits left in the power loop
   logic        redb_ff, redb_in;   // reducing b (else a)
   logic        div_ff, div_in;     // divide: second phase pending
   logic        bad_ff, bad_in;
   rsp_word_type rsp_ff, rsp_in;

   // shared unit: double acc mod n, then add x if bit set
   word_type   room_d, dbl, room_x, sum_out;
   logic       mbit;
   always_comb begin
      room_d = n_ff - acc_ff;
      dbl    = (acc_ff >= room_d) ? (acc_ff - room_d) : (acc_ff + acc_ff);
      room_x = n_ff - mx_ff;
      mbit   = my_ff[WORD_BITS-1];
      if (mbit)
         sum_out = (dbl >= room_x) ? (dbl - room_x) : (dbl + mx_ff);
      else
         sum_out = dbl;
   end

   // restoring reduction step: rem = rem*2 + bit, subtract n if possible
   logic [WORD_BITS:0] rsh;
   word_type           red_out;
   always_comb begin
      rsh     = {acc_ff, mx_ff[WORD_BITS-1]};
      red_out = (rsh >= {1'b0, n_ff}) ? word_type'(rsh - {1'b0, n_ff})
                                      : rsh[WORD_BITS-1:0];
   end

   word_type one_mod;
   assign one_mod = (n_ff == word_type'(1)) ? '0 : word_type'(1);

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  n_in = n_ff;
      b_in = b_ff;  e_in = e_ff;  ra_in = ra_ff;  acc_in = acc_ff;
      mx_in = mx_ff;  my_in = my_ff;  pacc_in = pacc_ff;  pbase_in = pbase_ff;
      cnt_in = cnt_ff;  redb_in = redb_ff;  div_in = div_ff;  bad_in = bad_ff;
      rsp_in = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_data.opcode;
               b_in   = word_type'(req_data.operand_b);
               // power uses the unreduced exponent
               e_in   = word_type'(req_data.operand_b);
               n_in   = word_type'(req_data.modulus);
               bad_in = (word_type'(req_data.modulus) == '0);
               acc_in = '0;
               mx_in  = word_type'(req_data.operand_a);
               cnt_in = CW'(WORD_BITS);
               redb_in = 1'b0;
               state_in = ST_RED;
            end
         end
         // reduce a, then b, one bit a cycle; a zero modulus goes straight to an error word
         ST_RED: begin
            if (bad_ff) begin
               rsp_in = '{result_value: '0, a_less_than_b: 1'b0,
                          a_equals_b: 1'b0, bad_modulus: 1'b1};
               state_in = ST_OUT;
            end else begin
               acc_in = red_out;
               mx_in  = mx_ff << 1;
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  if (!redb_ff) begin
                     ra_in = red_out;  acc_in = '0;  mx_in = b_ff;
                     cnt_in = CW'(WORD_BITS);  redb_in = 1'b1;
                  end else begin
                     b_in = red_out;  state_in = ST_DISP;
                  end
               end
            end
         end
         // choose the operation on reduced operands (ra_ff, b_ff)
         ST_DISP: begin
            rsp_in.a_less_than_b = (ra_ff < b_ff);
            rsp_in.a_equals_b    = (ra_ff == b_ff);
            rsp_in.bad_modulus   = 1'b0;
            rsp_in.result_value  = '0;
            acc_in = '0;  cnt_in = CW'(WORD_BITS);  div_in = 1'b0;
            case (op_ff)
               OP_ADD: begin
                  mx_in = ra_ff;  state_in = ST_DONE;  my_in = b_ff;
               end
               OP_SUB: begin
                  mx_in = ra_ff;  state_in = ST_DONE;
                  my_in = (b_ff == '0) ? '0 : (n_ff - b_ff);
               end
               OP_MUL: begin
                  mx_in = ra_ff;  my_in = b_ff;  div_in = 1'b0;
                  pacc_in = '0;  state_in = ST_MUL;
               end
               OP_DIV: begin
                  if (n_ff < word_type'(2)) state_in = ST_OUT;
                  else begin
                     pbase_in = b_ff;  e_in = n_ff - word_type'(2);
                     pacc_in = one_mod;  div_in = 1'b1;
                     mx_in = one_mod;  my_in = one_mod;  state_in = ST_POWSQ;
                  end
               end
               OP_POW: begin
                  pbase_in = ra_ff;
                  pacc_in = one_mod;  mx_in = one_mod;  my_in = one_mod;
                  state_in = ST_POWSQ;
               end
               default: state_in = ST_OUT;
            endcase
         end
         // multiply passes (square, multiply by base, plain multiply): acc = mx*my mod n, bit by bit
         ST_POWSQ, ST_POWML, ST_MUL: begin
            acc_in = sum_out;  my_in = my_ff << 1;  cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               acc_in = '0;  cnt_in = CW'(WORD_BITS);
               if (state_ff == ST_MUL) begin
                  rsp_in.result_value = FIELD_BITS'(sum_out);
                  state_in = ST_OUT;
               end else if (state_ff == ST_POWSQ && e_ff[WORD_BITS-1]) begin
                  pacc_in = sum_out;  mx_in = pbase_ff;  my_in = sum_out;
                  state_in = ST_POWML;
               end else begin
                  pacc_in = sum_out;  e_in = e_ff << 1;  redb_in = ~redb_ff;
                  if (ebit_ff == CW'(1)) begin
                     if (div_ff) begin
                        mx_in = ra_ff;  my_in = sum_out;  state_in = ST_MUL;
                     end else begin
                        rsp_in.result_value = FIELD_BITS'(sum_out);
                        state_in = ST_OUT;
                     end
                  end else begin
                     mx_in = sum_out;  my_in = sum_out;  state_in = ST_POWSQ;
                  end
               end
            end
         end
         // add / subtract: one modular add
         ST_DONE: begin
            rsp_in.result_value = FIELD_BITS'((ra_ff >= (n_ff - my_ff))
                                  ? (ra_ff - (n_ff - my_ff)) : (ra_ff + my_ff));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // exponent bit counter for the power loop
   always_comb begin
      ebit_in = ebit_ff;
      if (state_ff == ST_DISP) ebit_in = CW'(WORD_BITS);
      else if ((state_ff == ST_POWSQ || state_ff == ST_POWML) && cnt_ff == CW'(1)
               && !(state_ff == ST_POWSQ && e_ff[WORD_BITS-1]))
         ebit_in = ebit_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;  n_ff <= n_in;  b_ff <= b_in;  e_ff <= e_in;
      ra_ff <= ra_in;  acc_ff <= acc_in;  mx_ff <= mx_in;  my_ff <= my_in;
      pacc_ff <= pacc_in;  pbase_ff <= pbase_in;  cnt_ff <= cnt_in;
      redb_ff <= redb_in;  div_ff <= div_in;  bad_ff <= bad_in;
      rsp_ff <= rsp_in;  ebit_ff <= ebit_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   // result stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed under stall");
   // error words carry no compare flags
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_modulus |-> !rsp_data.a_equals_b && !rsp_data.a_less_than_b)
      else $error("flags on bad modulus");
   // never ready and valid together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while result pending");

endmodule

FILE: tb/sv/modular_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives opcode/operand/modulus words with random idling on both sides,
// predicts each result word at full width and checks it field by field.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit_tb;
   import mau_pkg::*;

   // Scoreboard: predicts result words and checks them in order
   class mau_scoreboard;
      rsp_word_type pending[$];
      int errors;

      function logic [31:0] mulmod(logic [31:0] x, logic [31:0] y,
                                   logic [31:0] n);
         logic [63:0] p;
         p = 64'(x) * 64'(y);
         return 32'(p % 64'(n));
      endfunction

      function logic [31:0] powmod(logic [31:0] base, logic [31:0] e,
                                   logic [31:0] n);
         logic [31:0] acc;
         acc = 32'(1) % n;
         for (int i = 31; i >= 0; i--) begin
            acc = mulmod(acc, acc, n);
            if (e[i]) acc = mulmod(acc, base, n);
         end
         return acc;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         logic [31:0] ra, rb, n;
         logic [32:0] s;
         r = '0;
         n = w.modulus;
         if (n == 0) begin
            r.bad_modulus = 1'b1;
         end else begin
            ra = w.operand_a % n;
            rb = w.operand_b % n;
            r.a_less_than_b = ra < rb;
            r.a_equals_b = ra == rb;
            case (w.opcode)
               OP_ADD: begin
                  s = 33'(ra) + 33'(rb);
                  r.result_value = 32'(s % 33'(n));
               end
               OP_SUB: begin
                  s = 33'(ra) + 33'(n) - 33'(rb);
                  r.result_value = 32'(s % 33'(n));
               end
               OP_MUL: r.result_value = mulmod(ra, rb, n);
               OP_DIV: r.result_value = (n >= 2) ? mulmod(ra, powmod(rb, n - 2, n), n) : '0;
               OP_POW: r.result_value = powmod(ra, w.operand_b, n);
               default: r.result_value = '0;
            endcase
         end
         pending.push_back(r);
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.result_value, got.result_value);
            errors++;
         end
         if (got.a_less_than_b !== want.a_less_than_b) begin
            $display("%0t: a_less_than_b expected %b actual %b", $time,
                     want.a_less_than_b, got.a_less_than_b);
            errors++;
         end
         if (got.a_equals_b !== want.a_equals_b) begin
            $display("%0t: a_equals_b expected %b actual %b", $time,
                     want.a_equals_b, got.a_equals_b);
            errors++;
         end
         if (got.bad_modulus !== want.bad_modulus) begin
            $display("%0t: bad_modulus expected %b actual %b", $time,
                     want.bad_modulus, got.bad_modulus);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   mau_scoreboard board = new();
   bit           calm = 1'b0;
   int           sent = 0;
   int           got_count = 0;
   int           pow_count = 0;
   int           div_count = 0;

   modular_arithmetic_unit dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard limit: fail if the run does not finish in time
   initial begin
      #(4 * 2600 * 300 * 4);
      $display("modular_arithmetic_unit test failed");
      $finish;
   end

   // Drain result words with random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
            got_count++;
         end
         rsp_ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // Drive one request word and hold until accepted
   task automatic send_word(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                            logic [31:0] n);
      req_word_type w;
      w.opcode = op;
      w.operand_a = a;
      w.operand_b = b;
      w.modulus = n;
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(w);
      if (op == OP_POW) pow_count++;
      if (op == OP_DIV) div_count++;
      sent++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFFF - $urandom_range(15);
         2: return $urandom_range(1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_modulus();
      logic [31:0] primes[6] = '{2, 3, 7, 65521, 2147483647, 4294967291};
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2, 3, 4: return primes[$urandom_range(5)];
         5: return $urandom_range(2, 100);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [2:0] op;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every opcode, zero and unit modulus, zero to zero
      for (int k = 0; k < 5; k++) begin
         send_word(k[2:0], 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFB);
         send_word(k[2:0], 0, 0, 0);
         send_word(k[2:0], 5, 9, 1);
      end
      send_word(OP_POW, 0, 0, 7);
      send_word(OP_POW, 0, 0, 32'hFFFF_FFFF);
      send_word(OP_DIV, 10, 14, 7);
      send_word(OP_DIV, 3, 5, 15);
      send_word(OP_SUB, 2, 9, 11);
      send_word(OP_SUB, 9, 9, 32'h8000_0000);
      send_word(3'd5, 4, 6, 13);
      send_word(3'd6, 7, 2, 13);
      send_word(3'd7, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);

      // Random words; a calm stretch in the middle
      for (int k = 0; k < 246; k++) begin
         calm = (k >= 100 && k < 140);
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(4));
         send_word(op, pick_value(), pick_value(), pick_modulus());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d request words (%0d power, %0d divide), checked %0d results.",
               sent, pow_count, div_count, got_count);
      if (board.errors == 0) begin
         $display("modular_arithmetic_unit test passed");
      end else begin
         $display("modular_arithmetic_unit test failed");
      end
      $finish;
   end

endmodule
